// ===== src/fca_pkg.sv =====
// shared types and constants for the chain allocator
`default_nettype none

package fca_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_APPEND = 2'd2,
    OP_NEXT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  // kind of a table entry: link to another block, end mark, or free
  typedef enum logic [1:0] {
    TAG_LINK = 2'd0,
    TAG_END  = 2'd1,
    TAG_FREE = 2'd2
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [IDX_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] new_chain_first;
    logic [IDX_W-1:0] next_block;
    logic             is_end;
    logic             is_free;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_NEXT,
    S_FREE_WALK,
    S_TAIL_WALK,
    S_SCAN,
    S_ALLOC_END,
    S_LINK_TAIL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/fca_table.sv =====
// link table memory: one write port, one registered read port, write forwarding
`default_nettype none

module fca_table
  import fca_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  entry_t mem [NUM_BLOCKS];
  entry_t rd_q;
  entry_t fwd_data;
  logic   fwd;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
    // read and write of the same entry in one cycle returns the new word
    fwd      <= req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr);
    fwd_data <= req.wr_data;
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

`default_nettype wire

// ===== src/fca_ctrl.sv =====
// sequencer for alloc, free, append and link read over the link table
`default_nettype none

module fca_ctrl
  import fca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       operation,
  input  wire logic [IDX_W-1:0] chain_start,
  input  wire logic [CNT_W-1:0] block_count,
  output logic                  done,
  input  wire logic             done_ack,
  output result_t               res,
  output mem_req_t              mem_req,
  input  wire entry_t           rd_data
);

  state_t           state;
  state_t           state_next;
  op_t              op;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] addr;
  logic [CNT_W-1:0] steps;
  logic [CNT_W-1:0] found;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] prev;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] data_addr;
  logic             pend;

  op_t  op_in;
  logic start_bad;
  logic e_free;
  logic e_end;
  logic e_link;
  logic walk_last;
  logic last_found;
  logic scan_issue;

  assign op_in      = op_t'(operation);
  assign start_bad  = {1'b0, chain_start} >= CNT_W'(NUM_BLOCKS);
  assign e_free     = (rd_data.tag == TAG_FREE);
  assign e_end      = (rd_data.tag == TAG_END);
  assign e_link     = !e_free && !e_end;
  assign walk_last  = (steps == CNT_W'(NUM_BLOCKS - 1));
  assign last_found = ((found + CNT_W'(1)) == count);
  assign scan_issue = (addr < CNT_W'(NUM_BLOCKS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (addr[IDX_W-1:0] == IDX_W'(NUM_BLOCKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_in)
            OP_ALLOC:  state_next = (block_count == '0 || block_count > free_cnt) ?
                                    S_DONE : S_SCAN;
            OP_FREE:   state_next = start_bad ? S_DONE : S_FREE_WALK;
            OP_APPEND: state_next = (start_bad || block_count == '0) ?
                                    S_DONE : S_TAIL_WALK;
            OP_NEXT:   state_next = start_bad ? S_DONE : S_READ_NEXT;
          endcase
        end
      end
      S_READ_NEXT: state_next = S_DONE;
      S_FREE_WALK: begin
        if (e_free || e_end || walk_last) state_next = S_DONE;
      end
      S_TAIL_WALK: begin
        priority if (e_free)                    state_next = S_DONE;
        else if (e_end && count > free_cnt)     state_next = S_DONE;
        else if (e_end)                         state_next = S_SCAN;
        else if (walk_last)                     state_next = S_DONE;
        else                                    state_next = S_TAIL_WALK;
      end
      S_SCAN: begin
        if (pend && e_free && last_found) state_next = S_ALLOC_END;
      end
      S_ALLOC_END: state_next = (op == OP_APPEND) ? S_LINK_TAIL : S_DONE;
      S_LINK_TAIL: state_next = S_DONE;
      S_DONE: begin
        if (done_ack) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and memory requests
  always_comb begin
    in_ready        = (state == S_IDLE);
    done            = (state == S_DONE);
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = cur;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = cur;
    mem_req.wr_data = '{tag: TAG_FREE, idx: '0};
    unique case (state)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = addr[IDX_W-1:0];
      end
      S_IDLE: begin
        mem_req.rd_en   = in_valid && !start_bad && (op_in != OP_ALLOC);
        mem_req.rd_addr = chain_start;
      end
      S_FREE_WALK: begin
        if (!e_free) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = cur;
          mem_req.rd_en   = e_link && !walk_last;
          mem_req.rd_addr = rd_data.idx;
        end
      end
      S_TAIL_WALK: begin
        mem_req.rd_en   = e_link && !walk_last;
        mem_req.rd_addr = rd_data.idx;
      end
      S_SCAN: begin
        mem_req.rd_en   = scan_issue;
        mem_req.rd_addr = addr[IDX_W-1:0];
        // link the previous block to the one just found
        if (pend && e_free && found != '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = prev;
          mem_req.wr_data = '{tag: TAG_LINK, idx: data_addr};
        end
      end
      S_ALLOC_END: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = prev;
        mem_req.wr_data = '{tag: TAG_END, idx: '0};
      end
      S_LINK_TAIL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tail;
        mem_req.wr_data = '{tag: TAG_LINK, idx: head};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      addr     <= '0;
      free_cnt <= CNT_W'(NUM_BLOCKS);
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: addr <= addr + CNT_W'(1);
        S_IDLE: begin
          if (in_valid) begin
            op    <= op_in;
            cur   <= chain_start;
            count <= block_count;
            steps <= '0;
            found <= '0;
            addr  <= '0;
            pend  <= 1'b0;
            res   <= '{status: ST_OK, new_chain_first: '0, next_block: '0,
                       is_end: 1'b0, is_free: 1'b0};
            unique case (op_in)
              OP_ALLOC: begin
                if (block_count == '0)           res.status <= ST_BAD;
                else if (block_count > free_cnt) res.status <= ST_NOSPACE;
              end
              OP_APPEND: begin
                if (start_bad || block_count == '0) res.status <= ST_BAD;
              end
              OP_FREE, OP_NEXT: begin
                if (start_bad) res.status <= ST_BAD;
              end
            endcase
          end
        end
        S_READ_NEXT: begin
          res.is_free <= e_free;
          res.is_end  <= e_end;
          if (e_link) res.next_block <= rd_data.idx;
        end
        S_FREE_WALK: begin
          if (e_free) begin
            // a free start entry is an error, a free later entry ends the walk
            if (steps == '0) res.status <= ST_BAD;
          end else begin
            free_cnt <= free_cnt + CNT_W'(1);
            steps    <= steps + CNT_W'(1);
            cur      <= rd_data.idx;
          end
        end
        S_TAIL_WALK: begin
          priority if (e_free) begin
            res.status <= ST_BAD;
          end else if (e_end) begin
            tail <= cur;
            if (count > free_cnt) res.status <= ST_NOSPACE;
          end else begin
            if (walk_last) res.status <= ST_BAD;
            cur   <= rd_data.idx;
            steps <= steps + CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (scan_issue) addr <= addr + CNT_W'(1);
          pend      <= scan_issue;
          data_addr <= addr[IDX_W-1:0];
          if (pend && e_free) begin
            if (found == '0) head <= data_addr;
            prev  <= data_addr;
            found <= found + CNT_W'(1);
          end
        end
        S_ALLOC_END: begin
          free_cnt            <= free_cnt - count;
          res.new_chain_first <= head;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/fat_chain_allocator.sv =====
// top level of the block chain allocator with output register and checks
`default_nettype none

// Keeps one link entry per data block in a single-port-write, registered-read
// memory and runs one request at a time. After reset a clearing pass marks
// all NUM_BLOCKS entries free, one per cycle, during which no request is
// taken. Read next reads the start entry and reports its link or mark. Free
// walks its chain, one entry per cycle through the memory's read-modify-write.
// Alloc scans the table from block 0, one entry per cycle, up to the last
// block it takes; a request that cannot fit is refused at once against a
// running count of free entries. Append adds the walk to the tail of its
// chain, one entry per cycle, to that of alloc, so the worst case is about
// two passes over the table. A result waits in the output register while
// the next request is accepted.
module fat_chain_allocator
  import fca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       operation,
  input  wire logic [IDX_W-1:0] chain_start,
  input  wire logic [CNT_W-1:0] block_count,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            status,
  output logic [IDX_W-1:0]      new_chain_first,
  output logic [IDX_W-1:0]      next_block,
  output logic                  is_end,
  output logic                  is_free
);

  mem_req_t mem_req;
  entry_t   rd_data;
  result_t  res;
  logic     done;
  logic     done_ack;

  fca_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  fca_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .chain_start (chain_start),
    .block_count (block_count),
    .done        (done),
    .done_ack    (done_ack),
    .res         (res),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  // output word register
  assign done_ack = done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ack) begin
      status          <= res.status;
      new_chain_first <= res.new_chain_first;
      next_block      <= res.next_block;
      is_end          <= res.is_end;
      is_free         <= res.is_free;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one still runs");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("request taken before the clearing pass");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      new_chain_first == '0 && next_block == '0 && !is_end && !is_free)
    else $error("failed request carries data");

  a_end_free_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_end && is_free))
    else $error("entry reported both end and free");

endmodule

`default_nettype wire
